@@ rtl/core/lslf_pkg.sv @@
// Shared types and constants for the least-squares line fit unit.
package lslf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_W       = 13;
    localparam int SX_W        = 28;
    localparam int SXX_W       = 44;
    localparam int OUT_W       = 48;
    localparam int NUM_W       = 96;
    localparam int DIV_W       = 128;
    localparam int QCNT_W      = 7;
    localparam int MUL_W       = 44;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEGEN    = 2'd1,
        ST_SAT      = 2'd2,
        ST_OVERRUN  = 2'd3
    } fit_status_t;

    typedef enum logic [3:0] {
        MSEL_N_SXX  = 4'd0,
        MSEL_SX_SX  = 4'd1,
        MSEL_N_SXY  = 4'd2,
        MSEL_SX_SY  = 4'd3,
        MSEL_SY_SXX = 4'd4,
        MSEL_SX_SXY = 4'd5
    } mul_sel_t;

    typedef struct packed {
        logic     accum;
        logic     clear;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     mul_sub;
        logic     mul_clr;
        logic     latch_den;
        logic     latch_num_s;
        logic     div_start;
        logic     div_sel_icpt;
        logic     latch_slope;
        logic     latch_icpt;
        logic     emit;
        logic     emit_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic overrun;
        logic den_zero;
        logic mul_done;
        logic div_done;
    } dp_stat_t;

endpackage

@@ rtl/core/lslf_datapath.sv @@
// Datapath: accumulators, shift-add multiplier and restoring divider.
module lslf_datapath
    import lslf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [15:0]       x_value,
    input  logic signed [15:0]       y_value,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    output logic signed [OUT_W-1:0]  slope,
    output logic signed [OUT_W-1:0]  intercept,
    output logic [1:0]               fit_status
);

    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SX_W-1:0]  sx_reg, sy_reg;
    logic signed [SXX_W-1:0] sxx_reg, sxy_reg;
    logic                    ovr_reg;
    logic                    sat_reg;

    logic signed [31:0] xx, xy;
    assign xx = x_value * x_value;
    assign xy = x_value * y_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
            ovr_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
            ovr_reg <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (cnt_reg < CNT_W'(MAX_SAMPLES))
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sx_reg  <= sx_reg + SX_W'(x_value);
                sy_reg  <= sy_reg + SX_W'(y_value);
                sxx_reg <= sxx_reg + SXX_W'(xx);
                sxy_reg <= sxy_reg + SXX_W'(xy);
            end
            else
            begin
                ovr_reg <= 1'b1;
            end
        end
    end

    // Serial signed multiply: one bit of the magnitude of b per cycle.
    logic signed [MUL_W-1:0] ma, mb;
    always_comb
    begin
        unique case (cmd.mul_sel)
            MSEL_N_SXX:  begin ma = MUL_W'(signed'({1'b0, cnt_reg})); mb = MUL_W'(sxx_reg); end
            MSEL_SX_SX:  begin ma = MUL_W'(sx_reg);  mb = MUL_W'(sx_reg);  end
            MSEL_N_SXY:  begin ma = MUL_W'(signed'({1'b0, cnt_reg})); mb = MUL_W'(sxy_reg); end
            MSEL_SX_SY:  begin ma = MUL_W'(sx_reg);  mb = MUL_W'(sy_reg);  end
            MSEL_SY_SXX: begin ma = MUL_W'(sy_reg);  mb = MUL_W'(sxx_reg); end
            MSEL_SX_SXY: begin ma = MUL_W'(sx_reg);  mb = MUL_W'(sxy_reg); end
            default:     begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [NUM_W-1:0] acc_reg, mcand_reg, term;
    logic [MUL_W-1:0]        mplier_reg;
    logic                    mneg_reg;
    logic [5:0]              mcnt_reg;
    logic                    mbusy_reg;
    logic signed [NUM_W-1:0] den_reg, nums_reg;

    assign term = mneg_reg ? -mcand_reg : mcand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else if (cmd.mul_go)
        begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= 6'(MUL_W);
        end
        else if (mbusy_reg)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
            if (mcnt_reg == 6'd1)
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_clr)
            acc_reg <= '0;
        if (cmd.mul_go)
        begin
            mcand_reg  <= NUM_W'(ma);
            mplier_reg <= mb[MUL_W-1] ? MUL_W'(-mb) : mb;
            mneg_reg   <= cmd.mul_sub ^ mb[MUL_W-1];
        end
        else if (mbusy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + term;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.latch_den)
            den_reg <= acc_reg;
        if (cmd.latch_num_s)
            nums_reg <= acc_reg;
    end

    assign stat.mul_done = mbusy_reg && (mcnt_reg == 6'd1);
    assign stat.den_zero = (den_reg == '0);
    assign stat.overrun  = ovr_reg;

    // Restoring divider, one quotient bit per cycle over magnitudes, with the dividend scaled by 2^F.
    logic signed [NUM_W-1:0] num_in;
    logic [DIV_W-1:0]        dvd_reg, dvs_reg, quo_reg;
    logic [DIV_W:0]          rem_reg, rem_sh, rem_sub;
    logic [QCNT_W:0]         dcnt_reg;
    logic                    dbusy_reg, dneg_reg;
    logic                    dfin_reg;
    logic [OUT_W-1:0]        qmag, lim, sat_val;
    logic                    qsat;

    assign num_in  = cmd.div_sel_icpt ? acc_reg : nums_reg;
    assign rem_sh  = {rem_reg[DIV_W-1:0], dvd_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
            dfin_reg  <= 1'b0;
        end
        else
        begin
            // quotient is complete in the cycle after the last shift
            dfin_reg <= dbusy_reg && (dcnt_reg == (QCNT_W+1)'(1));
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= (QCNT_W+1)'(DIV_W);
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == (QCNT_W+1)'(1))
                    dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= DIV_W'(num_in[NUM_W-1] ? -num_in : num_in) << FRAC_BITS;
            dvs_reg  <= DIV_W'(den_reg[NUM_W-1] ? -den_reg : den_reg);
            dneg_reg <= num_in[NUM_W-1] ^ den_reg[NUM_W-1];
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (dbusy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (!rem_sub[DIV_W])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = dfin_reg;

    assign lim  = dneg_reg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    assign qsat = (quo_reg[DIV_W-1:OUT_W] != '0) || (quo_reg[OUT_W-1:0] > lim);
    assign qmag = qsat ? lim : quo_reg[OUT_W-1:0];
    assign sat_val = dneg_reg ? -qmag : qmag;

    logic [OUT_W-1:0] slope_reg, icpt_reg;
    logic [1:0]       status_reg;
    logic             emit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_slope)
        begin
            slope_reg <= sat_val;
            sat_reg   <= qsat;
        end
        if (cmd.latch_icpt)
        begin
            icpt_reg <= sat_val;
            sat_reg  <= sat_reg | qsat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_reg <= 1'b0;
        else
            emit_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.emit_zero)
                status_reg <= ovr_reg ? ST_OVERRUN : ST_DEGEN;
            else
                status_reg <= sat_reg ? ST_SAT : ST_OK;
        end
    end

    logic zero_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            zero_reg <= cmd.emit_zero;
    end

    assign slope      = (emit_reg && !zero_reg) ? slope_reg : '0;
    assign intercept  = (emit_reg && !zero_reg) ? icpt_reg : '0;
    assign fit_status = emit_reg ? status_reg : ST_OK;

endmodule

@@ rtl/core/lslf_ctrl.sv @@
// Controller: sequences the solve after the last request.
module lslf_ctrl
    import lslf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     last_sample,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_M0     = 11'b00000000100,
        S_M1     = 11'b00000001000,
        S_DEN    = 11'b00000010000,
        S_M2     = 11'b00000100000,
        S_M3     = 11'b00001000000,
        S_DIVS   = 11'b00010000000,
        S_M4     = 11'b00100000000,
        S_DIVI   = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= cmd.emit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.mul_sel = MSEL_N_SXX;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accum = 1'b1;
                    if (last_sample)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.overrun)
                begin
                    cmd.emit = 1'b1; cmd.emit_zero = 1'b1; state_next = S_EMIT;
                end
                else
                begin
                    cmd.mul_clr = 1'b1; cmd.mul_go = 1'b1; cmd.mul_sel = MSEL_N_SXX;
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_go = 1'b1; cmd.mul_sel = MSEL_SX_SX; cmd.mul_sub = 1'b1;
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                if (stat.mul_done)
                    state_next = S_DEN;
            end
            S_DEN:
            begin
                if (!phase_reg)
                begin
                    cmd.latch_den = 1'b1; phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (stat.den_zero)
                    begin
                        cmd.emit = 1'b1; cmd.emit_zero = 1'b1; state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.mul_clr = 1'b1; cmd.mul_go = 1'b1; cmd.mul_sel = MSEL_N_SXY;
                        state_next = S_M2;
                    end
                end
            end
            S_M2:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_go = 1'b1; cmd.mul_sel = MSEL_SX_SY; cmd.mul_sub = 1'b1;
                    state_next = S_M3;
                end
            end
            S_M3:
            begin
                if (stat.mul_done)
                    state_next = S_DIVS;
            end
            S_DIVS:
            begin
                if (!phase_reg)
                begin
                    cmd.latch_num_s = 1'b1; phase_next = 1'b1;
                end
                else if (phase_reg && state_next == S_DIVS && !stat.div_done)
                begin
                    // start divider and mul for intercept together, in the same cycle
                    cmd.div_start = 1'b1;
                    cmd.mul_clr = 1'b1; cmd.mul_go = 1'b1; cmd.mul_sel = MSEL_SY_SXX;
                    phase_next = 1'b0;
                    state_next = S_M4;
                end
            end
            S_M4:
            begin
                // both intercept products finish well before the slope divide
                if (stat.mul_done && !phase_reg)
                begin
                    cmd.mul_go = 1'b1; cmd.mul_sel = MSEL_SX_SXY; cmd.mul_sub = 1'b1;
                    phase_next = 1'b1;
                end
                if (stat.div_done)
                begin
                    cmd.latch_slope = 1'b1;
                    phase_next = 1'b0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                if (!phase_reg)
                begin
                    cmd.div_start = 1'b1; cmd.div_sel_icpt = 1'b1; phase_next = 1'b1;
                end
                else if (stat.div_done)
                begin
                    cmd.latch_icpt = 1'b1;
                    phase_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!done_reg && !cmd.emit && !phase_reg)
                begin
                    cmd.emit = 1'b1; phase_next = 1'b1;
                end
                else
                begin
                    cmd.clear = 1'b1; phase_next = 1'b0; state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

@@ rtl/core/least_squares_line_fit_unit.sv @@
// Top level of the least-squares line fit unit.
// A sample request is accepted while the unit is idle; non-last samples allow one request per cycle.
// A last sample runs four multiplies, then two divides with the intercept products
// overlapped with the slope divide; a zero denominator or an overrun skips the rest of
// the solve. busy drops in the cycle after result_valid.
// Asynchronous active-low reset clears the sums, counters and controller.
module least_squares_line_fit_unit
    import lslf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [15:0]       x_value,
    input  logic signed [15:0]       y_value,
    input  logic                     last_sample,
    output logic                     result_valid,
    output logic signed [OUT_W-1:0]  slope,
    output logic signed [OUT_W-1:0]  intercept,
    output logic [1:0]               fit_status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     ctrl_busy;

    lslf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_sample (last_sample),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (ctrl_busy),
        .done        (result_valid)
    );

    lslf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .x_value    (x_value),
        .y_value    (y_value),
        .cmd        (cmd),
        .stat       (stat),
        .slope      (slope),
        .intercept  (intercept),
        .fit_status (fit_status)
    );

    assign busy = ctrl_busy;

endmodule

@@ rtl/core/lslf_checker.sv @@
// Port-level checker for the least-squares line fit unit.
module lslf_checker
    import lslf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              last_sample,
    input logic              result_valid,
    input logic [OUT_W-1:0]  slope,
    input logic [OUT_W-1:0]  intercept,
    input logic [1:0]        fit_status
);

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_sample |=> busy)
        else $error("last request did not raise busy");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a solve");

    a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result longer than one cycle");

    a_zero_deg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (fit_status == ST_DEGEN || fit_status == ST_OVERRUN)
            |-> (slope == '0) && (intercept == '0))
        else $error("degenerate result not zero");

endmodule

bind least_squares_line_fit_unit lslf_checker u_lslf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_sample  (last_sample),
    .result_valid (result_valid),
    .slope        (slope),
    .intercept    (intercept),
    .fit_status   (fit_status)
);
